@@ hw/rtl/mhpq_pkg.sv @@
// shared types and constants for the max heap priority queue
package mhpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 11;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

@@ hw/rtl/mhpq_req_if.sv @@
// request channel: operation and key
interface mhpq_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic signed [mhpq_pkg::KEY_W-1:0] key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink (input valid, input req_type, input key_value, output ready);
endinterface

@@ hw/rtl/mhpq_rsp_if.sv @@
// response channel: status, top key and entry count
interface mhpq_rsp_if;
  logic                               valid;
  logic                               ready;
  mhpq_pkg::status_t                  status;
  logic signed [mhpq_pkg::KEY_W-1:0]  top_value;
  logic                               top_valid;
  logic [mhpq_pkg::COUNT_W-1:0]       entry_count;

  modport source (output valid, output status, output top_value, output top_valid,
                  output entry_count, input ready);
  modport sink (input valid, input status, input top_value, input top_valid,
                input entry_count, output ready);
endinterface

@@ hw/rtl/max_heap_priority_queue.sv @@
// Bounded max-priority queue of signed 32-bit keys. Keys sit in a chain of
// CAPACITY cells kept sorted largest first; a push broadcasts the key and every
// cell decides in the same cycle whether to keep, take the new key or take its
// left neighbor's key, and a pop shifts the whole chain one cell toward the head.
// Each request updates the chain at once, and its response beat is registered and
// appears the cycle after the request is taken. A waiting response beat holds off
// the request side; the next request is taken in the cycle that beat is taken, so
// with the receiver ready requests follow back to back, one per cycle. Every
// request returns one beat with status (done, full, empty), the largest key held
// with a valid flag (the minimum integer when empty) and the entry count, low 11
// bits.
module max_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic clk,
  input  logic rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KW    = mhpq_pkg::KEY_W;
  localparam int CW    = mhpq_pkg::COUNT_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                   rsp_valid;
  mhpq_pkg::status_t      rsp_status;
  mhpq_pkg::status_t      status_next;
  logic signed [KW-1:0]   rsp_top;
  logic signed [KW-1:0]   top_next;
  logic                   rsp_top_valid;

  logic accept;
  logic full;
  logic empty;
  logic do_push;
  logic do_pop;

  mhpq_pkg::cell_cmd_t  cmd;
  logic signed [KW-1:0] cell_key [CAPACITY];
  logic                 cell_ge  [CAPACITY];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign do_push   = accept && (req.req_type == mhpq_pkg::REQ_PUSH) && !full;
  assign do_pop    = accept && (req.req_type == mhpq_pkg::REQ_POP) && !empty;

  assign cmd.push = do_push;
  assign cmd.pop  = do_pop;
  assign cmd.key  = req.key_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 left_ge;
    logic signed [KW-1:0] left_key;
    logic signed [KW-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_ge  = 1'b1;
      assign left_key = req.key_value;
    end else begin : g_body
      assign left_ge  = cell_ge[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    mhpq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (count > CNT_W'(i)),
      .left_ge   (left_ge),
      .left_key  (left_key),
      .right_key (right_key),
      .ge        (cell_ge[i]),
      .key       (cell_key[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = mhpq_pkg::ST_DONE;
    top_next    = empty ? mhpq_pkg::KEY_MIN : cell_key[0];
    if (req.req_type == mhpq_pkg::REQ_PUSH) begin
      if (full) begin
        status_next = mhpq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
        if (empty || (req.key_value > cell_key[0])) begin
          top_next = req.key_value;
        end
      end
    end else begin
      if (empty) begin
        status_next = mhpq_pkg::ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
        top_next   = (count == CNT_W'(1)) ? mhpq_pkg::KEY_MIN : cell_key[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status    <= status_next;
      rsp_top       <= top_next;
      rsp_top_valid <= (count_next != '0);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.top_value   = rsp_top;
  assign rsp.top_valid   = rsp_top_valid;
  assign rsp.entry_count = CW'(count);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push |=> count == CNT_W'($past(count) + 1'b1))
    else $error("accepted push did not grow the count");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("no response beat after an accepted request");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_top_valid == (count != '0)))
    else $error("top valid flag disagrees with entry count");

  a_top_is_head: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_top_valid) |-> (rsp_top == cell_key[0]))
    else $error("reported top differs from head cell");
`endif

endmodule

@@ hw/rtl/mhpq_cell.sv @@
// one slot of the sorted key chain, largest key at the head
module mhpq_cell (
  input  logic                              clk,
  input  mhpq_pkg::cell_cmd_t               cmd,
  input  logic                              occupied,
  input  logic                              left_ge,
  input  logic signed [mhpq_pkg::KEY_W-1:0] left_key,
  input  logic signed [mhpq_pkg::KEY_W-1:0] right_key,
  output logic                              ge,
  output logic signed [mhpq_pkg::KEY_W-1:0] key
);

  // this slot keeps its key on a push when it is occupied and ranks at or above the new key
  assign ge = occupied && (key >= cmd.key);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (!ge) begin
        key <= left_ge ? cmd.key : left_key;
      end
    end else if (cmd.pop) begin
      key <= right_key;
    end
  end

endmodule
